// ===== sv/kpe_pkg.sv =====
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared constants, types and the exponential table of the pair kernel block.
// ----------------------------------------------------------------------------
`default_nettype none

package kpe_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int TAB_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int TAB_PTR_W       = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int MAG_W           = COORD_WIDTH + 1;
  localparam int ACC_W           = 40;
  localparam int REG_W           = 24;
  localparam int CFG_IDX_W       = 2;

  localparam logic [ACC_W-1:0] ACC_MAX   = '1;
  localparam logic [63:0]      Q30_ONE   = 64'd1073741824;
  localparam logic [63:0]      LN2_Q30   = 64'd744261118;
  localparam logic [31:0]      LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0]      SQRT5_Q30 = 32'd2400959709;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LENGTHSCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE    = 2'd2;

  localparam logic [REG_W-1:0] IL_RESET    = 24'd65536;
  localparam logic [REG_W-1:0] SCALE_RESET = 24'd65536;

  // Operand pairs of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_ACC_LO,
    MUL_ACC_HI,
    MUL_S_HI,
    MUL_S_LO,
    MUL_X_LOG2E,
    MUL_D_REM,
    MUL_ROOT_SQRT5,
    MUL_A_SQ,
    MUL_POLY_E,
    MUL_BASE_SCALE
  } mul_sel_e;

  typedef struct packed {
    logic     take;
    logic     acc_add;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     tmp_load;
    logic     s_load;
    logic     u_load;
    logic     x_from_u;
    logic     a_load;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     poly_load;
    logic     y_load;
    logic     tab_load;
    logic     exp_load;
    logic     exp_zero;
    logic     base_from_exp;
    logic     base_from_prod;
    logic     base_zero;
    logic     load_out;
  } kpe_cmd_t;

  typedef struct packed {
    logic last;
    logic mode;
    logic u_ge_2p30;
    logic u_ge_2p32;
    logic cnt_last;
    logic a_big;
    logic k_big;
    logic out_full;
  } kpe_sts_t;

  typedef logic [30:0] pow2_tab_t [0:EXP_TABLE_DEPTH];

  // Table of 2^(-j/DEPTH) in Q.30, built at elaboration from the series of exp(-z).
  function automatic pow2_tab_t build_pow2_tab();
    pow2_tab_t   tab;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      z    = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
      term = Q30_ONE;
      pos  = Q30_ONE;
      neg  = '0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        if ((n & 1) != 0) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      tab[i] = (pos > neg) ? 31'(pos - neg) : '0;
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

`default_nettype wire

// ===== sv/kpe_ifs.sv =====
// ----------------------------------------------------------------------------
// kpe_ifs
// Channel interfaces: coordinate words in, kernel words out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpe_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [kpe_pkg::COORD_WIDTH-1:0] coord_a;
  logic signed [kpe_pkg::COORD_WIDTH-1:0] coord_b;
  logic                                   last_dim;
  modport source (output valid, coord_a, coord_b, last_dim, input ready);
  modport sink   (input valid, coord_a, coord_b, last_dim, output ready);
endinterface

interface kpe_out_if;
  logic                      valid;
  logic                      ready;
  logic [kpe_pkg::REG_W-1:0] kernel_value;
  logic                      saturated;
  modport source (output valid, kernel_value, saturated, input ready);
  modport sink   (input valid, kernel_value, saturated, output ready);
endinterface

interface kpe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kpe_pkg::CFG_IDX_W-1:0] index;
  logic [kpe_pkg::REG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/gp_kernel_pair_eval.sv =====
// ----------------------------------------------------------------------------
// gp_kernel_pair_eval
// RBF / Matern 2.5 covariance of one point pair, fed one dimension per word.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Carries                               Accepted when
//   item_i    in    coord_a, coord_b, last_dim            valid && ready
//   result_o  out   kernel_value (Q8.16), saturated       valid && ready
//   cfg_i     in    index, data (24 bits)                 valid && ready
//
// The difference of a coordinate word is captured in a register when the
// word is accepted, and its square is then added to the distance sum.
// A word marked last then starts the evaluation, which runs on one shared
// 33x32 multiplier; for Matern a 28-step bit-serial square root dominates.
// The result sits in an output register, so new words are taken while it
// waits; only the next evaluation's final step stalls on a full output.
// Reset is asynchronous and active low and clears the sum, the sequencer
// and the registers to their default values; configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module gp_kernel_pair_eval (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kpe_in_if.sink    item_i,
  kpe_out_if.source result_o,
  kpe_cfg_if.sink   cfg_i
);

  kpe_pkg::kpe_cmd_t cmd;
  kpe_pkg::kpe_sts_t sts;

  // Writes are taken in any cycle; software must only write when idle.
  assign cfg_i.ready = 1'b1;

  // The sequencer owns the input handshake and drives the datapath.
  kpe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // The datapath holds the distance sum, configuration and output register.
  kpe_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .coord_a_i      (item_i.coord_a),
    .coord_b_i      (item_i.coord_b),
    .last_dim_i     (item_i.last_dim),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .kernel_value_o (result_o.kernel_value),
    .saturated_o    (result_o.saturated)
  );

endmodule

`default_nettype wire

// ===== sv/kpe_dpath.sv =====
// ----------------------------------------------------------------------------
// kpe_dpath
// Datapath: accumulator, shared multiplier, square-root loop, divide by
// three, exponential table, configuration registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_dpath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire kpe_pkg::kpe_cmd_t                      cmd_i,
  output kpe_pkg::kpe_sts_t                           sts_o,
  input  wire logic signed [kpe_pkg::COORD_WIDTH-1:0] coord_a_i,
  input  wire logic signed [kpe_pkg::COORD_WIDTH-1:0] coord_b_i,
  input  wire logic                                   last_dim_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic [kpe_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [kpe_pkg::REG_W-1:0]              cfg_data_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [kpe_pkg::REG_W-1:0]                   kernel_value_o,
  output logic                                        saturated_o
);

  localparam int MW = kpe_pkg::MAG_W;
  localparam int AW = kpe_pkg::ACC_W;
  localparam int IW = kpe_pkg::TAB_IDX_W;
  localparam int TAB_IDX_W_L = kpe_pkg::TAB_PTR_W;

  // Configuration and control state.
  logic                      mode_q;
  logic [kpe_pkg::REG_W-1:0] il_q;
  logic [kpe_pkg::REG_W-1:0] scale_q;
  logic [AW-1:0]             acc_q;
  logic                      last_q;
  logic [5:0]                cnt_q;
  logic                      out_valid_q;

  // Payload registers.
  logic [MW-1:0] mag_q;
  logic [64:0]   prod_q;
  logic [47:0]   tmp_q;
  logic [47:0]   s_q;
  logic [55:0]   u_q;
  logic [28:0]   x_q;
  logic [28:0]   a_q;
  logic [55:0]   rv_q;
  logic [55:0]   res_q;
  logic [33:0]   nsh_q;
  logic [32:0]   quo_q;
  logic [32:0]   poly_q;
  logic [29:0]   y_q;
  logic [30:0]   hi_q;
  logic [30:0]   lo_q;
  logic [30:0]   exp_q;
  logic [32:0]   base_q;
  logic [23:0]   val_q;
  logic          sat_q;

  // Squared difference and saturating accumulate.
  logic [MW-1:0]   diff;
  logic [MW-1:0]   mag_d;
  logic [2*MW-1:0] sq_full;
  logic [AW-1:0]   sq;
  logic [AW:0]     acc_sum;

  assign diff    = {coord_a_i[kpe_pkg::COORD_WIDTH-1], coord_a_i}
                 - {coord_b_i[kpe_pkg::COORD_WIDTH-1], coord_b_i};
  assign mag_d   = diff[MW-1] ? (~diff + MW'(1)) : diff;
  assign sq_full = mag_q * mag_q;
  assign sq      = ((mag_q >> 20) != '0) ? kpe_pkg::ACC_MAX : AW'(sq_full);
  assign acc_sum = {1'b0, acc_q} + {1'b0, sq};

  // Shared multiplier operands.
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [30:0] tab_d;
  logic [23:0] tab_rem;

  assign tab_d   = (hi_q > lo_q) ? (hi_q - lo_q) : '0;
  assign tab_rem = {y_q[23-IW:0], IW'(0)};

  always_comb begin
    case (cmd_i.mul_sel)
      kpe_pkg::MUL_ACC_LO:     begin mul_a = 33'(acc_q[19:0]);  mul_b = 32'(il_q); end
      kpe_pkg::MUL_ACC_HI:     begin mul_a = 33'(acc_q[39:20]); mul_b = 32'(il_q); end
      kpe_pkg::MUL_S_HI:       begin mul_a = 33'(s_q[47:24]);   mul_b = 32'(il_q); end
      kpe_pkg::MUL_S_LO:       begin mul_a = 33'(s_q[23:0]);    mul_b = 32'(il_q); end
      kpe_pkg::MUL_X_LOG2E:    begin mul_a = 33'(x_q);          mul_b = kpe_pkg::LOG2E_Q30; end
      kpe_pkg::MUL_D_REM:      begin mul_a = 33'(tab_d);        mul_b = 32'(tab_rem); end
      kpe_pkg::MUL_ROOT_SQRT5: begin mul_a = 33'(res_q[27:0]);  mul_b = kpe_pkg::SQRT5_Q30; end
      kpe_pkg::MUL_A_SQ:       begin mul_a = 33'(a_q);          mul_b = 32'(a_q); end
      kpe_pkg::MUL_POLY_E:     begin mul_a = poly_q;            mul_b = 32'(exp_q[30:6]); end
      kpe_pkg::MUL_BASE_SCALE: begin mul_a = base_q;            mul_b = 32'(scale_q); end
      default:                 begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  // Arithmetic between steps.
  logic [63:0] s_sum;
  logic [55:0] u_sum;
  logic [55:0] sq_bit;
  logic [55:0] sq_try;
  logic [60:0] y_sum;
  logic [30:0] exp_v;
  logic [5:0]  exp_k;
  logic [64:0] out_sum;
  logic [TAB_IDX_W_L-1:0] tab_idx;

  // Divide by three of a 34-bit value: with n = h * 2^17 + l and
  // 2^17 = 3 * 43690 + 2, n / 3 = h * 43690 + (2h + l) / 3, and the small
  // quotient comes from a multiply by (2^21 + 1) / 3 and a shift by 21.
  logic [16:0] d3_hi;
  logic [18:0] d3_x;
  logic [38:0] d3_xm;
  logic [32:0] d3_q;

  assign s_sum   = {prod_q[43:0], 20'b0} + 64'(tmp_q[43:0]);
  assign u_sum   = {tmp_q, 8'b0} + 56'(prod_q[47:16]);
  assign sq_bit  = 56'(1) << {cnt_q, 1'b0};
  assign sq_try  = res_q + sq_bit;
  assign y_sum   = 61'(prod_q[59:0]) + (61'(1) << 29);
  assign exp_k   = y_q[29:24];
  assign exp_v   = hi_q - prod_q[54:24];
  assign out_sum = prod_q + (65'(1) << 23);
  assign tab_idx = TAB_IDX_W_L'(y_q[23:24-IW]);

  assign d3_hi = nsh_q[33:17];
  assign d3_x  = {1'b0, d3_hi, 1'b0} + 19'(nsh_q[16:0]);
  assign d3_xm = 39'(d3_x) * 39'(20'd699051);
  assign d3_q  = 33'(d3_hi) * 33'(16'd43690) + 33'(d3_xm[38:21]);

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      il_q        <= kpe_pkg::IL_RESET;
      scale_q     <= kpe_pkg::SCALE_RESET;
      acc_q       <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kpe_pkg::REG_KERNEL_MODE:     mode_q  <= cfg_data_i[0];
          kpe_pkg::REG_INV_LENGTHSCALE: il_q    <= cfg_data_i;
          kpe_pkg::REG_OUTPUT_SCALE:    scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        last_q <= last_dim_i;
      end
      if (cmd_i.acc_add) begin
        acc_q <= acc_sum[AW] ? kpe_pkg::ACC_MAX : acc_sum[AW-1:0];
      end else if (cmd_i.load_out) begin
        acc_q <= '0;
      end
      if (cmd_i.sqrt_init) begin
        cnt_q <= 6'd27;
      end else if (cmd_i.sqrt_step) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the evaluation sequence.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mag_q <= mag_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= prod_q[47:0];
    end
    if (cmd_i.s_load) begin
      s_q <= s_sum[63:16];
    end
    if (cmd_i.u_load) begin
      u_q <= u_sum;
    end
    if (cmd_i.x_from_u) begin
      x_q <= u_q[29:1];
    end else if (cmd_i.a_load) begin
      x_q <= prod_q[58:30];
    end
    if (cmd_i.a_load) begin
      a_q <= prod_q[58:30];
    end
    if (cmd_i.sqrt_init) begin
      rv_q  <= {u_q[31:0], 24'b0};
      res_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (rv_q >= sq_try) begin
        rv_q  <= rv_q - sq_try;
        res_q <= (res_q >> 1) + sq_bit;
      end else begin
        res_q <= res_q >> 1;
      end
    end
    if (cmd_i.div_init) begin
      nsh_q <= prod_q[57:24];
    end
    if (cmd_i.div_step) begin
      quo_q <= d3_q;
    end
    if (cmd_i.poly_load) begin
      poly_q <= (33'(1) << 24) + 33'(a_q) + quo_q;
    end
    if (cmd_i.y_load) begin
      y_q <= y_sum[59:30];
    end
    if (cmd_i.tab_load) begin
      hi_q <= kpe_pkg::POW2_TAB[tab_idx];
      lo_q <= kpe_pkg::POW2_TAB[tab_idx + TAB_IDX_W_L'(1)];
    end
    if (cmd_i.exp_zero) begin
      exp_q <= '0;
    end else if (cmd_i.exp_load) begin
      exp_q <= exp_v >> exp_k;
    end
    if (cmd_i.base_zero) begin
      base_q <= '0;
    end else if (cmd_i.base_from_exp) begin
      base_q <= 33'(exp_q[30:6]);
    end else if (cmd_i.base_from_prod) begin
      base_q <= prod_q[56:24];
    end
    if (cmd_i.load_out) begin
      sat_q <= |out_sum[64:48];
      val_q <= (|out_sum[64:48]) ? '1 : out_sum[47:24];
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.last      = last_q;
    sts_o.mode      = mode_q;
    sts_o.u_ge_2p30 = |u_q[55:30];
    sts_o.u_ge_2p32 = |u_q[55:32];
    sts_o.cnt_last  = (cnt_q == '0);
    sts_o.a_big     = |prod_q[64:59];
    sts_o.k_big     = (exp_k >= 6'd31);
    sts_o.out_full  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign kernel_value_o = val_q;
  assign saturated_o    = sat_q;

  // The sum is cleared once a result has been handed to the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> acc_q == '0)
    else $error("distance sum not cleared after result");

  // A finished root fits in 28 bits before it is scaled by sqrt(5).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul_en && cmd_i.mul_sel == kpe_pkg::MUL_ROOT_SQRT5) |-> res_q[55:28] == '0)
    else $error("square root exceeds 28 bits");

  // A waiting result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("waiting result withdrawn");

  // A result is never written over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("output register overwritten");

endmodule

`default_nettype wire

// ===== sv/kpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpe_ctrl
// Sequencer: accepts coordinate words and steps the datapath through the
// kernel evaluation after the last dimension.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  input  wire kpe_pkg::kpe_sts_t sts_i,
  output kpe_pkg::kpe_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_M_ACC_LO, ST_M_ACC_HI, ST_S, ST_M_SHI, ST_M_SLO, ST_U,
    ST_CHECK, ST_SQRT, ST_AM, ST_AA, ST_PM, ST_DIVINIT, ST_DIV, ST_POLY,
    ST_EM1, ST_EY, ST_ETAB, ST_EM2, ST_EV, ST_BASE, ST_BB, ST_FM, ST_OUT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_sel = kpe_pkg::MUL_ACC_LO;
    item_ready_o = 1'b0;
    state_d      = state_q;
    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.acc_add = 1'b1;
        state_d = sts_i.last ? ST_M_ACC_LO : ST_IDLE;
      end
      ST_M_ACC_LO: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_ACC_LO;
        state_d = ST_M_ACC_HI;
      end
      ST_M_ACC_HI: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_ACC_HI;
        cmd_o.tmp_load = 1'b1;
        state_d = ST_S;
      end
      ST_S: begin
        cmd_o.s_load = 1'b1;
        state_d = ST_M_SHI;
      end
      ST_M_SHI: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_S_HI;
        state_d = ST_M_SLO;
      end
      ST_M_SLO: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_S_LO;
        cmd_o.tmp_load = 1'b1;
        state_d = ST_U;
      end
      ST_U: begin
        cmd_o.u_load = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts_i.mode) begin
          if (sts_i.u_ge_2p30) begin
            cmd_o.base_zero = 1'b1; state_d = ST_FM;
          end else begin
            cmd_o.x_from_u = 1'b1; state_d = ST_EM1;
          end
        end else if (sts_i.u_ge_2p32) begin
          cmd_o.base_zero = 1'b1; state_d = ST_FM;
        end else begin
          cmd_o.sqrt_init = 1'b1; state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_AM;
        end
      end
      ST_AM: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_ROOT_SQRT5;
        state_d = ST_AA;
      end
      ST_AA: begin
        if (sts_i.a_big) begin
          cmd_o.base_zero = 1'b1; state_d = ST_FM;
        end else begin
          cmd_o.a_load = 1'b1; state_d = ST_PM;
        end
      end
      ST_PM: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_A_SQ;
        state_d = ST_DIVINIT;
      end
      ST_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d = ST_POLY;
      end
      ST_POLY: begin
        cmd_o.poly_load = 1'b1;
        state_d = ST_EM1;
      end
      ST_EM1: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_X_LOG2E;
        state_d = ST_EY;
      end
      ST_EY: begin
        cmd_o.y_load = 1'b1;
        state_d = ST_ETAB;
      end
      ST_ETAB: begin
        if (sts_i.k_big) begin
          cmd_o.exp_zero = 1'b1; state_d = ST_BASE;
        end else begin
          cmd_o.tab_load = 1'b1; state_d = ST_EM2;
        end
      end
      ST_EM2: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_D_REM;
        state_d = ST_EV;
      end
      ST_EV: begin
        cmd_o.exp_load = 1'b1;
        state_d = ST_BASE;
      end
      ST_BASE: begin
        if (!sts_i.mode) begin
          cmd_o.base_from_exp = 1'b1; state_d = ST_FM;
        end else begin
          cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_POLY_E;
          state_d = ST_BB;
        end
      end
      ST_BB: begin
        cmd_o.base_from_prod = 1'b1;
        state_d = ST_FM;
      end
      ST_FM: begin
        cmd_o.mul_en = 1'b1; cmd_o.mul_sel = kpe_pkg::MUL_BASE_SCALE;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_gp_kernel_pair_eval.sv =====
// ----------------------------------------------------------------------------
// tb_gp_kernel_pair_eval
// Self-checking testbench of the RBF / Matern 2.5 pair kernel block.
// Coordinate words are driven from a directed table and then at random.
// Every word marked last is run through a bit-exact predictor, and the
// kernel words that come out are compared in order with those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gp_kernel_pair_eval;

  // A register index that selects no register.
  localparam logic [kpe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  kpe_in_if  item_ch ();
  kpe_out_if res_ch ();
  kpe_cfg_if cfg_ch ();

  gp_kernel_pair_eval dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch.sink),
    .result_o(res_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  // A kernel word as the block should give it.
  typedef struct {
    logic [23:0] kernel_value;
    logic        saturated;
  } kernel_word_t;

  // A row of the directed table. A typed-in expectation is used instead of
  // the predictor where has_exp is set.
  typedef struct {
    logic [15:0] coord_a;
    logic [15:0] coord_b;
    logic        last_dim;
    logic        has_exp;
    logic [23:0] exp_value;
    logic        exp_sat;
  } dir_row_t;

  // Predictor state: its own copy of the registers and the distance sum.
  logic        mdl_mode;
  logic [23:0] mdl_il;
  logic [23:0] mdl_scale;
  logic [39:0] mdl_dist_sq;
  logic [63:0] pow2_lut [0:kpe_pkg::EXP_TABLE_DEPTH];

  kernel_word_t kernel_q[$];
  int           n_errors = 0;
  bit           hold_sink = 1'b0;
  int           hold_cycles = 0;
  bit           no_idle = 1'b0;

  // Table of 2^(-j/256) in Q.30 from the series of exp(-z).
  function automatic logic [63:0] series_exp(logic [63:0] z);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1073741824;
    pos  = term;
    neg  = '0;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // exp(-x), x in Q.24, result in Q.30.
  function automatic logic [63:0] exp_of_neg(logic [63:0] x);
    logic [63:0] y;
    logic [63:0] k;
    logic [63:0] scaled;
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] d;
    if (x >= (64'd32 << 24)) return 64'd0;
    y = (x * 64'd1549082005 + (64'd1 << 29)) >> 30;
    k = y >> 24;
    if (k >= 31) return 64'd0;
    scaled = (y & 64'hFFFFFF) * kpe_pkg::EXP_TABLE_DEPTH;
    idx = scaled >> 24;
    rem = scaled & 64'hFFFFFF;
    if (idx >= kpe_pkg::EXP_TABLE_DEPTH) idx = kpe_pkg::EXP_TABLE_DEPTH - 1;
    hi = pow2_lut[idx];
    lo = pow2_lut[idx + 1];
    d  = (hi > lo) ? hi - lo : 64'd0;
    return (hi - ((d * rem) >> 24)) >> k;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Adds one dimension to the distance sum and, on the last one, queues the
  // kernel word it produces. A typed-in expectation overrides the predictor.
  task automatic predict_kernel(input logic [15:0] ca, input logic [15:0] cb,
                                input logic last, input logic has_exp,
                                input logic [23:0] ev, input logic es);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] s;
    logic [63:0] u;
    logic [63:0] base;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] poly;
    logic [63:0] val;
    logic [63:0] il;
    kernel_word_t w;
    diff = longint'($signed(ca)) - longint'($signed(cb));
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    sq   = (mag >= (64'd1 << 20)) ? 64'hFF_FFFF_FFFF : mag * mag;
    if (sq > 64'hFF_FFFF_FFFF - 64'(mdl_dist_sq)) mdl_dist_sq = '1;
    else mdl_dist_sq = mdl_dist_sq + 40'(sq);
    if (!last) return;
    il = 64'(mdl_il);
    s  = (64'(mdl_dist_sq) * il) >> 16;
    u  = (((s >> 24) * il) << 8) + (((s & 64'hFFFFFF) * il) >> 16);
    if (!mdl_mode) begin
      base = exp_of_neg(u >> 1) >> 6;
    end else if (u >= (64'd1 << 32)) begin
      base = 0;
    end else begin
      r    = int_sqrt(u << 24);
      a    = (r * 64'd2400959709) >> 30;
      poly = (64'd1 << 24) + a + ((a * a) >> 24) / 3;
      base = (poly * (exp_of_neg(a) >> 6)) >> 24;
    end
    val = (base * 64'(mdl_scale) + (64'd1 << 23)) >> 24;
    w.saturated    = (val > 64'hFFFFFF);
    w.kernel_value = w.saturated ? 24'hFFFFFF : val[23:0];
    mdl_dist_sq = '0;
    if (has_exp) begin
      if (w.kernel_value !== ev || w.saturated !== es) begin
        $error("directed row: predictor gives %0d/%0b, table says %0d/%0b",
               w.kernel_value, w.saturated, ev, es);
        n_errors++;
      end
      w.kernel_value = ev;
      w.saturated    = es;
    end
    kernel_q.push_back(w);
  endtask

  // Register write; the predictor copy is updated on acceptance.
  task automatic write_reg(input logic [kpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      kpe_pkg::REG_KERNEL_MODE:     mdl_mode  = val[0];
      kpe_pkg::REG_INV_LENGTHSCALE: mdl_il    = val;
      kpe_pkg::REG_OUTPUT_SCALE:    mdl_scale = val;
      default: ;
    endcase
  endtask

  // Sends one coordinate word, with occasional idle cycles ahead of it.
  task automatic send_word(input logic [15:0] ca, input logic [15:0] cb,
                           input logic last, input logic has_exp,
                           input logic [23:0] ev, input logic es);
    while (!no_idle && $urandom_range(99) < 7) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid    <= 1'b1;
    item_ch.coord_a  <= ca;
    item_ch.coord_b  <= cb;
    item_ch.last_dim <= last;
    do @(posedge clk_i); while (!item_ch.ready);
    predict_kernel(ca, cb, last, has_exp, ev, es);
  endtask

  task automatic stop_sending();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every kernel word has arrived, then lets the longest
  // evaluation run out before the block is treated as idle.
  task automatic drain();
    stop_sending();
    while (kernel_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // A vector pair of random length and content; mostly small differences
  // so that the kernel lands in its interesting range.
  task automatic send_pair();
    int          dims;
    logic [15:0] ca;
    logic [15:0] cb;
    dims = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(4, 1);
    for (int i = 0; i < dims; i++) begin
      ca = 16'($urandom);
      case ($urandom_range(3))
        0: cb = 16'($urandom);
        1: cb = ca + 16'($urandom_range(8191)) - 16'd4096;
        default: cb = ca + 16'($urandom_range(1023)) - 16'd512;
      endcase
      send_word(ca, cb, i == dims - 1, 1'b0, '0, 1'b0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (kernel_q.size() == 0) begin
          $error("kernel word %0d/%0b with none expected",
                 res_ch.kernel_value, res_ch.saturated);
          n_errors++;
        end else begin
          if (res_ch.kernel_value !== kernel_q[0].kernel_value) begin
            $error("kernel_value: expected %0d, got %0d",
                   kernel_q[0].kernel_value, res_ch.kernel_value);
            n_errors++;
          end
          if (res_ch.saturated !== kernel_q[0].saturated) begin
            $error("saturated: expected %0b, got %0b",
                   kernel_q[0].saturated, res_ch.saturated);
            n_errors++;
          end
          void'(kernel_q.pop_front());
        end
      end
      if (hold_sink) begin
        res_ch.ready <= 1'b0;
        hold_cycles  <= hold_cycles + 1;
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  // Directed rows: extremes, zero distance, pairs of more than one dimension,
  // and large distances that give a zero kernel.
  dir_row_t dir_rows[] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 24'd65536, 1'b0},
    '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 24'd65536, 1'b0},
    '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 24'd0,     1'b0},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b1, 24'd0,     1'b0},
    '{16'h1000, 16'h0000, 1'b1, 1'b0, 24'd0,     1'b0},
    '{16'h0800, 16'h0000, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'hF800, 16'h0000, 1'b1, 1'b0, 24'd0,     1'b0},
    '{16'h0001, 16'h0000, 1'b1, 1'b0, 24'd0,     1'b0},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'hAAAA, 16'h5555, 1'b1, 1'b1, 24'd0,     1'b0}
  };

  initial begin
    logic [23:0] il_set [] = '{24'd65536, 24'hFFFFFF, 24'd1, 24'd0, 24'd20000};
    logic [23:0] sc_set [] = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd1, 24'd300000};
    item_ch.valid    <= 1'b0;
    item_ch.coord_a  <= '0;
    item_ch.coord_b  <= '0;
    item_ch.last_dim <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= kpe_pkg::REG_KERNEL_MODE;
    cfg_ch.data      <= '0;
    for (int i = 0; i <= kpe_pkg::EXP_TABLE_DEPTH; i++) begin
      pow2_lut[i] = series_exp((64'(i) * 64'd744261118 + 64'd128) / 64'd256);
    end
    mdl_mode    = 1'b0;
    mdl_il      = 24'd65536;
    mdl_scale   = 24'd65536;
    mdl_dist_sq = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset settings, in both kernel modes.
    for (int m = 0; m < 2; m++) begin
      foreach (dir_rows[i]) begin
        send_word(dir_rows[i].coord_a, dir_rows[i].coord_b, dir_rows[i].last_dim,
                  dir_rows[i].has_exp, dir_rows[i].exp_value, dir_rows[i].exp_sat);
      end
      drain();
      write_reg(kpe_pkg::REG_KERNEL_MODE, 24'hFFFFFF);
    end
    // An unused index must leave the registers alone.
    write_reg(REG_UNUSED, 24'h123456);
    // Largest output: unit kernel times the largest scale just fits.
    write_reg(kpe_pkg::REG_OUTPUT_SCALE, 24'hFFFFFF);
    send_word(16'h0000, 16'h0000, 1'b1, 1'b1, 24'hFFFFFF, 1'b0);
    drain();
    // Zero inverse lengthscale gives a unit kernel whatever the distance.
    write_reg(kpe_pkg::REG_OUTPUT_SCALE, 24'd65536);
    write_reg(kpe_pkg::REG_INV_LENGTHSCALE, 24'd0);
    send_word(16'h7FFF, 16'h8000, 1'b1, 1'b1, 24'd65536, 1'b0);
    drain();

    // Random phases through the settings, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(kpe_pkg::REG_KERNEL_MODE, 24'($urandom));
      write_reg(kpe_pkg::REG_INV_LENGTHSCALE,
                (ph < 5) ? il_set[ph] : 24'($urandom_range(200000, 1)));
      write_reg(kpe_pkg::REG_OUTPUT_SCALE,
                (ph < 5) ? sc_set[ph] : 24'($urandom));
      no_idle = (ph == 3);
      if (ph == 6) begin
        // Long hold-off of the receiver while words keep coming.
        hold_sink = 1'b1;
        fork
          begin
            wait (hold_cycles >= 400);
            hold_sink = 1'b0;
          end
        join_none
      end
      for (int p = 0; p < 17; p++) send_pair();
      if (ph == 4) begin
        // Sender pauses until every expected word is in.
        stop_sending();
        while (kernel_q.size() != 0) @(posedge clk_i);
        for (int p = 0; p < 10; p++) send_pair();
      end
      drain();
    end
    no_idle = 1'b0;
    drain();
    if (n_errors == 0) begin
      $display("gp_kernel_pair_eval test passed");
    end else begin
      $display("gp_kernel_pair_eval test failed");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #(12 * 2000000);
    $display("gp_kernel_pair_eval test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/kpe_pkg.sv
sv/kpe_ifs.sv
sv/kpe_dpath.sv
sv/kpe_ctrl.sv
sv/gp_kernel_pair_eval.sv
tb/tb_gp_kernel_pair_eval.sv
